// ===== rtl/brians_brain_automaton_assert.svh =====
`ifndef BRIANS_BRAIN_AUTOMATON_ASSERT_SVH
`define BRIANS_BRAIN_AUTOMATON_ASSERT_SVH

// checked at every clock edge outside reset
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every clock edge, reset included
`define BBA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
package bba_pkg;

  localparam int ROW_W      = 7;
  localparam int COL_W      = 8;
  localparam int CELL_W     = 2;
  localparam int ACT_W      = 2;
  localparam int ROWS_W     = 8;
  localparam int COLS_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 8'd70;
  localparam logic [COLS_W-1:0] COLS_RESET = 9'd130;

  localparam logic [CELL_W-1:0] CELL_DEAD  = 2'd0;
  localparam logic [CELL_W-1:0] CELL_LIVE  = 2'd1;
  localparam logic [CELL_W-1:0] CELL_DYING = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_CALC
  } state_e;

  // one column of the 3x3 neighborhood window
  typedef struct packed {
    logic [CELL_W-1:0] top;
    logic [CELL_W-1:0] mid;
    logic [CELL_W-1:0] bot;
  } column_t;

endpackage

// ===== rtl/bba_grid.sv =====
module bba_grid #(
  parameter int DEPTH = 32768,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [bba_pkg::CELL_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [bba_pkg::CELL_W-1:0] rdata_o
);
  import bba_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bba_linebuf.sv =====
module bba_linebuf #(
  parameter int MAX_COLS = 256,
  parameter int CW       = $clog2(MAX_COLS)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [CW:0]                waddr_i,
  input  logic [bba_pkg::CELL_W-1:0] wdata_i,
  input  logic [CW:0]                raddr_a_i,
  input  logic [CW:0]                raddr_b_i,
  output logic [bba_pkg::CELL_W-1:0] rdata_a_o,
  output logic [bba_pkg::CELL_W-1:0] rdata_b_o
);
  import bba_pkg::*;

  localparam int DEPTH = 2 ** (CW + 1);

  // two row slots, selected by the top address bit
  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_a_q;
  logic [CELL_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/bba_rule.sv =====
module bba_rule (
  input  bba_pkg::column_t [2:0]     win_i,
  output logic [bba_pkg::CELL_W-1:0] next_o
);
  import bba_pkg::*;

  logic [7:0] live;
  logic       two_live;

  assign live = {win_i[0].top == CELL_LIVE, win_i[0].mid == CELL_LIVE,
                 win_i[0].bot == CELL_LIVE, win_i[1].top == CELL_LIVE,
                 win_i[1].bot == CELL_LIVE, win_i[2].top == CELL_LIVE,
                 win_i[2].mid == CELL_LIVE, win_i[2].bot == CELL_LIVE};

  assign two_live = ($countones(live) == 2);

  always_comb begin
    case (win_i[1].mid)
      CELL_LIVE:  next_o = CELL_DYING;
      CELL_DYING: next_o = CELL_DEAD;
      default:    next_o = two_live ? CELL_LIVE : CELL_DEAD;
    endcase
  end

endmodule

// ===== rtl/brians_brain_automaton.sv =====
// channel   | direction | ports                                       | handshake
// ----------+-----------+---------------------------------------------+------------------
// request   | in        | action_i row_i col_i value_i                | start_i & !busy_o
// result    | out       | cell_state_o out_of_range_o                 | done_o, one cycle
// config    | in        | cfg_index_i cfg_data_i                      | cfg_valid_i & cfg_ready_o
//
// write: result in the cycle after the request, busy_o stays low
// read: result through the registered grid port and the result register
// advance: row 0 is loaded into the line buffer, then every row is swept, one cell per
//   cycle through the grid read and write ports and the rule unit
// clear and reset: sweep of all MAX_ROWS*MAX_COLS cells, one cell per cycle
// results cannot be stalled; config is always ready
module brians_brain_automaton #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [bba_pkg::ACT_W-1:0]      action_i,
  input  logic [bba_pkg::ROW_W-1:0]      row_i,
  input  logic [bba_pkg::COL_W-1:0]      col_i,
  input  logic [bba_pkg::CELL_W-1:0]     value_i,
  output logic                           done_o,
  output logic [bba_pkg::CELL_W-1:0]     cell_state_o,
  output logic                           out_of_range_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bba_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int CNW   = $clog2(MAX_COLS + 2);
  localparam int NRW   = $clog2(MAX_ROWS + 1);

  // configuration
  logic [ROWS_W-1:0] rows_q;
  logic [COLS_W-1:0] cols_q;
  logic [NRW-1:0]    nr;
  logic [CNW-1:0]    nc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_ROWS) begin
        rows_q <= cfg_data_i[ROWS_W-1:0];
      end else if (cfg_index_i == CFG_COLS) begin
        cols_q <= cfg_data_i[COLS_W-1:0];
      end
    end
  end

  assign nr = (32'(rows_q) > MAX_ROWS) ? NRW'(MAX_ROWS) : NRW'(rows_q);
  assign nc = (32'(cols_q) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(cols_q);

  // request decode
  state_e            state_q, state_d;
  action_e           act;
  logic              accept;
  logic              in_oor;
  logic [AW-1:0]     in_addr;
  logic [CELL_W-1:0] wr_value;
  logic              area_empty;

  assign busy_o     = (state_q != ST_IDLE);
  assign accept     = start_i && !busy_o;
  assign act        = action_e'(action_i);
  assign in_oor     = (32'(row_i) >= 32'(nr)) || (32'(col_i) >= 32'(nc));
  assign in_addr    = AW'(32'(row_i) * MAX_COLS + 32'(col_i));
  assign wr_value   = (value_i == CELL_LIVE || value_i == CELL_DYING) ? value_i : CELL_DEAD;
  assign area_empty = (nr == '0) || (nc == '0);

  // sweep and generation counters
  logic [AW-1:0]     clr_q;
  logic              clr_resp_q;
  logic [CNW-1:0]    fc_q;
  logic              a1_v_q;
  logic [CNW-1:0]    a1_col_q;
  logic              w_v_q;
  logic [CNW-1:0]    w_col_q;
  logic [NRW-1:0]    r_q;
  logic [AW-1:0]     row_base_q;
  logic              pi_q;
  column_t [2:0]     win_q;
  column_t           col_new;

  logic issue;
  logic a1_edge;
  logic cp_last;
  logic row_end;
  logic last_row;
  logic clr_last;

  assign issue    = ((state_q == ST_COPY) && (fc_q < nc)) ||
                    ((state_q == ST_CALC) && (fc_q <= nc));
  assign a1_edge  = (a1_col_q >= nc);
  assign cp_last  = (state_q == ST_COPY) && a1_v_q && ((a1_col_q + CNW'(1)) == nc);
  assign row_end  = (state_q == ST_CALC) && w_v_q && (w_col_q == nc);
  assign last_row = ((r_q + NRW'(1)) == nr);
  assign clr_last = (clr_q == AW'(DEPTH - 1));

  // memories and rule unit
  logic              g_we;
  logic [AW-1:0]     g_waddr;
  logic [CELL_W-1:0] g_wdata;
  logic [AW-1:0]     g_raddr;
  logic [CELL_W-1:0] g_rdata;
  logic              lb_we;
  logic [CW:0]       lb_waddr;
  logic [CW:0]       lb_raddr_a;
  logic [CW:0]       lb_raddr_b;
  logic [CELL_W-1:0] lb_rdata_a;
  logic [CELL_W-1:0] lb_rdata_b;
  logic [CELL_W-1:0] rule_next;

  bba_grid #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  bba_linebuf #(
    .MAX_COLS (MAX_COLS),
    .CW       (CW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .we_i      (lb_we),
    .waddr_i   (lb_waddr),
    .wdata_i   (g_rdata),
    .raddr_a_i (lb_raddr_a),
    .raddr_b_i (lb_raddr_b),
    .rdata_a_o (lb_rdata_a),
    .rdata_b_o (lb_rdata_b)
  );

  bba_rule u_rule (
    .win_i  (win_q),
    .next_o (rule_next)
  );

  // grid port: item access, clear sweep, row fetch and write-back
  always_comb begin
    g_we    = 1'b0;
    g_waddr = in_addr;
    g_wdata = wr_value;
    g_raddr = in_addr;
    case (state_q)
      ST_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_q;
        g_wdata = CELL_DEAD;
      end
      ST_IDLE: begin
        g_we = accept && (act == ACT_WRITE) && !in_oor;
      end
      ST_COPY: begin
        g_raddr = AW'(32'(row_base_q) + 32'(fc_q));
      end
      ST_CALC: begin
        // fetch the row below, write back the cell behind the window
        g_raddr = AW'(32'(row_base_q) + MAX_COLS + 32'(fc_q));
        g_we    = w_v_q && (w_col_q != '0);
        g_waddr = AW'(32'(row_base_q) + 32'(w_col_q) - 1);
        g_wdata = rule_next;
      end
      default: begin
        g_we = 1'b0;
      end
    endcase
  end

  // slot pi_q holds the old current row, the other slot the old row above;
  // the row below is copied into the upper slot as it streams past
  assign lb_we      = a1_v_q && ((state_q == ST_COPY) || ((state_q == ST_CALC) && !a1_edge));
  assign lb_waddr   = {(state_q == ST_COPY) ? pi_q : ~pi_q, a1_col_q[CW-1:0]};
  assign lb_raddr_a = {~pi_q, fc_q[CW-1:0]};
  assign lb_raddr_b = {pi_q, fc_q[CW-1:0]};

  // cells off the in-use area count as dead
  always_comb begin
    col_new.top = (r_q == '0 || a1_edge) ? CELL_DEAD : lb_rdata_a;
    col_new.mid = a1_edge ? CELL_DEAD : lb_rdata_b;
    col_new.bot = (last_row || a1_edge) ? CELL_DEAD : g_rdata;
  end

  // sequencer
  logic              done_q, done_d;
  logic              oor_q, oor_d;
  logic [CELL_W-1:0] cell_q, cell_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oor_q  <= oor_d;
    cell_q <= cell_d;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    oor_d   = 1'b0;
    cell_d  = CELL_DEAD;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
          done_d  = clr_resp_q;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_WRITE: begin
              done_d = 1'b1;
              oor_d  = in_oor;
            end
            ACT_READ: begin
              if (in_oor) begin
                done_d = 1'b1;
                oor_d  = 1'b1;
              end else begin
                state_d = ST_READ;
              end
            end
            ACT_STEP: begin
              if (area_empty) begin
                done_d = 1'b1;
              end else begin
                state_d = ST_COPY;
              end
            end
            ACT_CLEAR: begin
              state_d = ST_CLEAR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        cell_d  = g_rdata;
      end
      ST_COPY: begin
        if (cp_last) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (row_end && last_row) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_resp_q <= 1'b0;
      fc_q       <= '0;
      a1_v_q     <= 1'b0;
      a1_col_q   <= '0;
      w_v_q      <= 1'b0;
      w_col_q    <= '0;
      r_q        <= '0;
      row_base_q <= '0;
      pi_q       <= 1'b0;
    end else begin
      if (accept && act == ACT_CLEAR) begin
        clr_q      <= '0;
        clr_resp_q <= 1'b1;
      end else if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end

      if ((accept && act == ACT_STEP) || cp_last || (row_end && !last_row)) begin
        fc_q <= '0;
      end else if (issue) begin
        fc_q <= fc_q + CNW'(1);
      end

      a1_v_q   <= issue;
      a1_col_q <= fc_q;
      w_v_q    <= (state_q == ST_CALC) && a1_v_q;
      w_col_q  <= a1_col_q;

      if (accept && act == ACT_STEP) begin
        r_q        <= '0;
        row_base_q <= '0;
      end else if (row_end && !last_row) begin
        r_q        <= r_q + NRW'(1);
        row_base_q <= AW'(32'(row_base_q) + MAX_COLS);
      end

      if (row_end) begin
        pi_q <= ~pi_q;
      end
    end
  end

  // neighborhood window, cleared to dead at the start of each row
  always_ff @(posedge clk_i) begin
    if (cp_last || (row_end && !last_row)) begin
      win_q <= '0;
    end else if ((state_q == ST_CALC) && a1_v_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= col_new;
    end
  end

  assign done_o         = done_q;
  assign cell_state_o   = cell_q;
  assign out_of_range_o = oor_q;

endmodule

// ===== rtl/bba_checker.sv =====
`include "brians_brain_automaton_assert.svh"

module bba_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic [bba_pkg::ACT_W-1:0]  action_i,
  input logic                       done_o,
  input logic [bba_pkg::CELL_W-1:0] cell_state_o,
  input logic                       out_of_range_o
);
  import bba_pkg::*;

  `BBA_ASSERT(a_fields_need_done,
              (out_of_range_o || cell_state_o != CELL_DEAD) |-> done_o,
              "result fields set without strobe")

  `BBA_ASSERT(a_write_one_cycle,
              (start_i && !busy_o && action_i == ACT_WRITE) |=> (done_o && !busy_o),
              "write request did not finish in one cycle")

  `BBA_ASSERT(a_clear_holds_off,
              (start_i && !busy_o && action_i == ACT_CLEAR) |=> (busy_o && !done_o),
              "clear request did not start a sweep")

  `BBA_ASSERT(a_step_done_or_busy,
              (start_i && !busy_o && action_i == ACT_STEP) |=> (done_o != busy_o),
              "advance request neither finished nor started")

  // state register settles on the first edge in reset, so check at the edge after it
  `BBA_ASSERT_RST(a_reset_sweep, !rst_ni |=> busy_o, "block not busy during reset")

endmodule

bind brians_brain_automaton bba_checker u_bba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .action_i       (action_i),
  .done_o         (done_o),
  .cell_state_o   (cell_state_o),
  .out_of_range_o (out_of_range_o)
);

// ===== sim/brians_brain_automaton_tb.sv =====
module brians_brain_automaton_tb;
  import bba_pkg::*;

  localparam int GRID_ROWS      = 128;
  localparam int GRID_COLS      = 256;
  localparam int BIRTH_COUNT    = 2;
  localparam int WATCHDOG_LIMIT = 140000;
  localparam int DRAIN_TAIL     = 16;
  localparam int MAX_REPORTS    = 10;

  // codes the package leaves unnamed
  localparam logic [CELL_W-1:0]    CELL_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0] cell_state;
    logic              out_of_range;
  } cell_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [ACT_W-1:0]      action_i = ACT_READ;
  logic [ROW_W-1:0]      row_i = '0;
  logic [COL_W-1:0]      col_i = '0;
  logic [CELL_W-1:0]     value_i = CELL_DEAD;
  logic                  done_o;
  logic [CELL_W-1:0]     cell_state_o;
  logic                  out_of_range_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predicted grid and registers
  logic [CELL_W-1:0] board [GRID_ROWS*GRID_COLS];
  logic [CELL_W-1:0] prior_gen [GRID_ROWS*GRID_COLS];
  logic [ROWS_W-1:0] rows_cfg = ROWS_RESET;
  logic [COLS_W-1:0] cols_cfg = COLS_RESET;

  cell_report_t pending_reports[$];
  int           mismatch_count = 0;
  int           stall_cycles = 0;
  bit           idle_bursts = 1'b1;

  brians_brain_automaton #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .cell_state_o  (cell_state_o),
    .out_of_range_o(out_of_range_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic int area_rows();
    return (rows_cfg > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg);
  endfunction

  function automatic int area_cols();
    return (cols_cfg > GRID_COLS) ? GRID_COLS : int'(cols_cfg);
  endfunction

  function automatic void clear_board();
    foreach (board[i]) board[i] = CELL_DEAD;
  endfunction

  // one generation over the in-use area, neighbors taken from the old copy
  function automatic void evolve_board();
    int nr, nc, live_nb, rr, cc;
    nr = area_rows();
    nc = area_cols();
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        prior_gen[r*GRID_COLS+c] = board[r*GRID_COLS+c];
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        case (prior_gen[r*GRID_COLS+c])
          CELL_LIVE:  board[r*GRID_COLS+c] = CELL_DYING;
          CELL_DYING: board[r*GRID_COLS+c] = CELL_DEAD;
          default: begin
            live_nb = 0;
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                // no wrap: anything past the area edge is dead
                if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc &&
                    prior_gen[rr*GRID_COLS+cc] == CELL_LIVE)
                  live_nb++;
              end
            end
            board[r*GRID_COLS+c] = (live_nb == BIRTH_COUNT) ? CELL_LIVE : CELL_DEAD;
          end
        endcase
      end
    end
  endfunction

  function automatic cell_report_t predict_request(action_e act, logic [ROW_W-1:0] r,
                                                   logic [COL_W-1:0] c, logic [CELL_W-1:0] v);
    cell_report_t rep;
    int idx;
    rep = '0;
    idx = int'(r) * GRID_COLS + int'(c);
    case (act)
      ACT_WRITE, ACT_READ: begin
        if (int'(r) >= area_rows() || int'(c) >= area_cols()) begin
          rep.out_of_range = 1'b1;
        end else if (act == ACT_WRITE) begin
          board[idx] = (v > CELL_DYING) ? CELL_DEAD : v;
        end else begin
          rep.cell_state = board[idx];
        end
      end
      ACT_STEP:  evolve_board();
      ACT_CLEAR: clear_board();
    endcase
    return rep;
  endfunction

  task automatic send_request(action_e act, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                              logic [CELL_W-1:0] v);
    int gap;
    start_i  <= 1'b1;
    action_i <= act;
    row_i    <= r;
    col_i    <= c;
    value_i  <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_reports.push_back(predict_request(act, r, c, v));
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop requesting and wait until every result is in and the block is idle
  task automatic drain_requests();
    start_i <= 1'b0;
    while (pending_reports.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data,
                                bit keep_valid);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (!keep_valid) cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ROWS: rows_cfg = data[ROWS_W-1:0];
      CFG_COLS: cols_cfg = data[COLS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure_area(int nrows, int ncols);
    drain_requests();
    write_register(CFG_ROWS, CFG_DATA_W'(nrows), 1'b1);
    write_register(CFG_COLS, CFG_DATA_W'(ncols), 1'b0);
  endtask

  function automatic logic [ROW_W-1:0] pick_row(bit in_area);
    int top;
    if ($urandom_range(0, 9) == 0) return ROW_W'($urandom());
    top = in_area ? area_rows() - 1 : area_rows();
    if (top < 0) top = 0;
    if (top > GRID_ROWS - 1) top = GRID_ROWS - 1;
    return ROW_W'($urandom_range(0, top));
  endfunction

  function automatic logic [COL_W-1:0] pick_col(bit in_area);
    int top;
    if ($urandom_range(0, 9) == 0) return COL_W'($urandom());
    top = in_area ? area_cols() - 1 : area_cols();
    if (top < 0) top = 0;
    if (top > GRID_COLS - 1) top = GRID_COLS - 1;
    return COL_W'($urandom_range(0, top));
  endfunction

  // grid comes out of reset dead, default area is 70 x 130
  task automatic test_reset_defaults();
    send_request(ACT_READ, 7'd0, 8'd0, CELL_DEAD);
    send_request(ACT_READ, 7'd69, 8'd129, CELL_DEAD);
    send_request(ACT_READ, 7'd70, 8'd0, CELL_DEAD);
    send_request(ACT_READ, 7'd0, 8'd130, CELL_DEAD);
    send_request(ACT_READ, 7'd127, 8'd255, CELL_DEAD);
  endtask

  task automatic test_write_read();
    send_request(ACT_WRITE, 7'd0, 8'd0, CELL_LIVE);
    send_request(ACT_WRITE, 7'd69, 8'd129, CELL_DYING);
    send_request(ACT_WRITE, 7'd0, 8'd1, CELL_LIVE);
    send_request(ACT_WRITE, 7'd0, 8'd1, CELL_UNUSED);
    send_request(ACT_WRITE, 7'd127, 8'd255, CELL_LIVE);
    send_request(ACT_READ, 7'd0, 8'd0, CELL_DEAD);
    send_request(ACT_READ, 7'd69, 8'd129, CELL_DEAD);
    send_request(ACT_READ, 7'd0, 8'd1, CELL_DEAD);
  endtask

  // register values past the grid size clamp to the full grid
  task automatic test_full_area();
    configure_area(9'h1FF, 9'h1FF);
    send_request(ACT_WRITE, 7'd127, 8'd255, CELL_LIVE);
    send_request(ACT_STEP, 7'd0, 8'd0, CELL_DEAD);
    send_request(ACT_READ, 7'd127, 8'd255, CELL_DEAD);
    send_request(ACT_READ, 7'd0, 8'd0, CELL_DEAD);
  endtask

  task automatic test_empty_area();
    drain_requests();
    write_register(CFG_UNUSED, CFG_DATA_W'($urandom()), 1'b1);
    write_register(CFG_ROWS, '0, 1'b1);
    write_register(CFG_COLS, 9'd5, 1'b0);
    send_request(ACT_READ, 7'd0, 8'd0, CELL_DEAD);
    send_request(ACT_WRITE, 7'd0, 8'd0, CELL_LIVE);
    configure_area(5, 0);
    send_request(ACT_STEP, 7'd0, 8'd0, CELL_DEAD);
    configure_area(5, 5);
    send_request(ACT_READ, 7'd0, 8'd0, CELL_DEAD);
  endtask

  // clear reaches cells outside the area as well
  task automatic test_clear_grid();
    send_request(ACT_CLEAR, 7'd0, 8'd0, CELL_DEAD);
    send_request(ACT_READ, 7'd0, 8'd0, CELL_DEAD);
    configure_area(GRID_ROWS, GRID_COLS);
    send_request(ACT_READ, 7'd127, 8'd255, CELL_DEAD);
  endtask

  task automatic test_random_generations();
    int nrows, ncols, roll, clears_left;
    logic [CELL_W-1:0] v;
    clears_left = 1;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          nrows = $urandom_range(3, 6);
          ncols = $urandom_range(3, 8);
        end
        1: begin
          nrows = $urandom_range(1, 3);
          ncols = $urandom_range(GRID_COLS + 1, 511);
        end
        2: begin
          nrows = $urandom_range(GRID_ROWS + 1, 255);
          ncols = $urandom_range(1, 3);
        end
        default: begin
          nrows = $urandom_range(1, 8);
          ncols = $urandom_range(1, 12);
        end
      endcase
      // last stretch runs back to back
      if (phase == 7) idle_bursts = 1'b0;
      configure_area(nrows, ncols);
      repeat (4) send_request(ACT_WRITE, pick_row(1'b1), pick_col(1'b1), CELL_LIVE);
      repeat (8) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          v = $urandom_range(0, 1) ? CELL_LIVE : CELL_W'($urandom_range(0, 3));
          send_request(ACT_WRITE, pick_row(1'b1), pick_col(1'b1), v);
        end else if (roll < 78) begin
          send_request(ACT_READ, pick_row(1'b0), pick_col(1'b0), CELL_W'($urandom()));
        end else if (roll < 98 || clears_left == 0) begin
          send_request(ACT_STEP, ROW_W'($urandom()), COL_W'($urandom()), CELL_W'($urandom()));
        end else begin
          clears_left--;
          send_request(ACT_CLEAR, ROW_W'($urandom()), COL_W'($urandom()), CELL_W'($urandom()));
        end
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin
    cell_report_t want;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: state %0d oor %0d",
                                  cell_state_o, out_of_range_o));
      end else begin
        want = pending_reports.pop_front();
        if (cell_state_o !== want.cell_state || out_of_range_o !== want.out_of_range)
          report_mismatch($sformatf("expected state %0d oor %0d, got state %0d oor %0d",
                                    want.cell_state, want.out_of_range,
                                    cell_state_o, out_of_range_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    clear_board();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_write_read();
    test_full_area();
    test_empty_area();
    test_clear_grid();
    test_random_generations();
    drain_requests();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
